// File: rtl/imu_yaw_frame_qualifier_defines.svh
// assertion macros for the imu yaw frame qualifier checker
// expects signals named clk and rst_n in the scope that uses them
`ifndef IMU_YAW_FRAME_QUALIFIER_DEFINES_SVH
`define IMU_YAW_FRAME_QUALIFIER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IYFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IYFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/iyfq_pkg.sv
// shared types and constants for the imu yaw frame qualifier
// no dependencies
`default_nettype none

package iyfq_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int YAW_W = 13;
    localparam int REL_W = 12;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W = 16;
    localparam int LIMIT_W = 4;

    // configuration register indexes
    localparam logic CFG_STARTUP_DELAY = 1'b0;
    localparam logic CFG_FAILURE_LIMIT = 1'b1;

    localparam logic [DELAY_W-1:0] STARTUP_DELAY_RST = 16'd5000;
    localparam logic [LIMIT_W-1:0] FAILURE_LIMIT_RST = 4'd4;

    // read_kind codes
    localparam logic [1:0] READ_NONE    = 2'd0;
    localparam logic [1:0] READ_VERSION = 2'd1;
    localparam logic [1:0] READ_ANGLE   = 2'd2;

    // 572.957795 in q10.22, rounded
    localparam logic [31:0] YAW_SCALE_Q22 = 32'd2403159171;
    // |yaw| of 6.5 as a single bit pattern, sign dropped
    localparam logic [30:0] YAW_LIMIT_BITS = 31'h40D00000;

    typedef struct packed {
        logic                    in_range;
        logic signed [YAW_W-1:0] tenths;
    } yaw_conv_t;

endpackage

`default_nettype wire

// File: rtl/iyfq_yaw_conv.sv
// single-precision yaw (radians) to tenths of a degree, range check included
// depends on iyfq_pkg
`default_nettype none

module iyfq_yaw_conv
(
    input  wire logic [31:0]      yaw_bits,
    output iyfq_pkg::yaw_conv_t   conv
);

    logic [7:0]  expo;
    logic [23:0] mant;
    logic [55:0] prod;
    logic [7:0]  shift_full;
    logic [5:0]  shift_amt;
    logic [55:0] shifted;
    logic [13:0] rnd;
    logic [12:0] mag;
    logic        tiny;

    assign expo = yaw_bits[30:23];
    assign mant = {(expo != 8'd0), yaw_bits[22:0]};

    // 24 x 32 exact product
    assign prod = 56'(mant) * 56'(iyfq_pkg::YAW_SCALE_Q22);

    // below exponent 116 the result rounds to zero (subnormals too)
    assign tiny       = (expo < 8'd116);
    assign shift_full = 8'd171 - expo;
    assign shift_amt  = shift_full[5:0];
    assign shifted    = prod >> shift_amt;

    // keep one extra bit, then round half away from zero
    assign rnd = shifted[13:0] + 14'd1;
    assign mag = tiny ? 13'd0 : rnd[13:1];

    assign conv.in_range = (yaw_bits[30:0] <= iyfq_pkg::YAW_LIMIT_BITS);
    assign conv.tenths   = yaw_bits[31] ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

// File: rtl/imu_yaw_frame_qualifier.sv
// imu yaw frame qualifier top level: input register, qualification pass, state
// depends on iyfq_pkg and iyfq_yaw_conv
`default_nettype none

// Qualifies one sensor frame per transaction. A transaction is taken into an
// input register, qualified in one pass against the block state (warm-up,
// version capture, yaw decode with range check and scaling, failure counting)
// and the updated state is presented as the result from the state registers,
// behind the input register; a new transaction is accepted every cycle while
// the result side keeps up. The state registers double as the result
// register: they only advance when the result slot is free, so a stalled
// result holds. Configuration writes (startup delay, failure limit) take
// effect at once and are meant to be issued while no transaction is in
// flight. The relative yaw is wrapped into (-180.0, 180.0] degrees, in
// tenths, straight from the stored yaw and reference.

module imu_yaw_frame_qualifier
#(
    parameter int COUNT_WIDTH = iyfq_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // configuration
    input  wire logic                                  cfg_write,
    input  wire logic                                  cfg_index,
    input  wire logic [iyfq_pkg::CFG_DATA_W-1:0]       cfg_data,

    // frame input
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire logic                                  action,
    input  wire logic [31:0]                           now_ms,
    input  wire logic                                  read_ok,
    input  wire logic [23:0]                           version_bytes,
    input  wire logic [31:0]                           yaw_bits,

    // result output
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic                                  ready_res,
    output      logic                                  warming_up,
    output      logic                                  version_valid,
    output      logic [1:0]                            read_kind,
    output      logic signed [iyfq_pkg::YAW_W-1:0]     yaw_tenths,
    output      logic signed [iyfq_pkg::REL_W-1:0]     relative_yaw_tenths,
    output      logic [COUNT_WIDTH-1:0]                good_frames,
    output      logic [COUNT_WIDTH-1:0]                bad_frames,
    output      logic [23:0]                           version_out
);

    localparam int YW = iyfq_pkg::YAW_W;
    localparam int DW = YW + 1;

    localparam logic signed [DW-1:0] HALF_TURN    = DW'(1800);
    localparam logic signed [DW-1:0] FULL_TURN    = DW'(3600);
    localparam logic signed [DW-1:0] ONE_HALF     = DW'(5400);
    localparam logic signed [DW-1:0] TWO_TURNS    = DW'(7200);

    // configuration registers
    logic [iyfq_pkg::DELAY_W-1:0] delay_reg;
    logic [iyfq_pkg::LIMIT_W-1:0] limit_reg;

    // input register
    logic        s1_valid_reg,  s1_valid_next;
    logic        s1_action_reg;
    logic [31:0] s1_now_reg;
    logic        s1_ok_reg;
    logic [23:0] s1_ver_reg;
    logic [31:0] s1_bits_reg;

    // block state, also the result register
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 kind_reg,      kind_next;
    logic                       warm_reg,      warm_next;
    logic                       ver_flag_reg,  ver_flag_next;
    logic [23:0]                ver_store_reg, ver_store_next;
    logic                       ready_reg,     ready_next;
    logic [iyfq_pkg::LIMIT_W-1:0] run_reg,     run_next;
    logic [COUNT_WIDTH-1:0]     good_reg,      good_next;
    logic [COUNT_WIDTH-1:0]     bad_reg,       bad_next;
    logic signed [YW-1:0]       yaw_reg,       yaw_next;
    logic signed [YW-1:0]       ref_reg,       ref_next;

    logic                       out_free;
    logic                       advance;
    logic                       take_in;
    logic                       active;
    logic                       fail;
    logic [iyfq_pkg::LIMIT_W-1:0] run_inc;
    logic signed [DW-1:0]       delta;
    logic signed [DW-1:0]       delta_wrap;

    iyfq_pkg::yaw_conv_t        conv;

    iyfq_yaw_conv u_conv
    (
        .yaw_bits (s1_bits_reg),
        .conv     (conv)
    );

    // handshake: the result slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // qualification pass for the transaction in the input register
    always_comb
    begin
        kind_next      = iyfq_pkg::READ_NONE;
        warm_next      = warm_reg;
        ver_flag_next  = ver_flag_reg;
        ver_store_next = ver_store_reg;
        ready_next     = ready_reg;
        run_next       = run_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        yaw_next       = yaw_reg;
        ref_next       = ref_reg;
        active         = 1'b0;
        fail           = 1'b0;
        run_inc        = (run_reg < limit_reg) ? run_reg + 1'b1 : run_reg;

        if (s1_action_reg)
        begin
            // capture the current yaw as reference, nothing else moves
            ref_next = yaw_reg;
        end
        else if (warm_reg)
        begin
            if (s1_now_reg >= 32'(delay_reg))
            begin
                warm_next = 1'b0;
                active    = 1'b1;
            end
        end
        else
        begin
            active = 1'b1;
        end

        if (active)
        begin
            if (!ver_flag_reg)
            begin
                kind_next = iyfq_pkg::READ_VERSION;
                if (s1_ok_reg)
                begin
                    ver_store_next = s1_ver_reg;
                    ver_flag_next  = 1'b1;
                    run_next       = '0;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else
            begin
                kind_next = iyfq_pkg::READ_ANGLE;
                if (!s1_ok_reg || !conv.in_range)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    yaw_next   = conv.tenths;
                    run_next   = '0;
                    ready_next = 1'b1;
                    // first good angle becomes the reference
                    if (good_reg == '0)
                    begin
                        ref_next = conv.tenths;
                    end
                    if (!(&good_reg))
                    begin
                        good_next = good_reg + 1'b1;
                    end
                end
            end
        end

        if (fail)
        begin
            if (!(&bad_reg))
            begin
                bad_next = bad_reg + 1'b1;
            end
            run_next = run_inc;
            if (run_inc >= limit_reg)
            begin
                ready_next = 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= iyfq_pkg::STARTUP_DELAY_RST;
            limit_reg <= iyfq_pkg::FAILURE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                iyfq_pkg::CFG_STARTUP_DELAY: delay_reg <= cfg_data[iyfq_pkg::DELAY_W-1:0];
                iyfq_pkg::CFG_FAILURE_LIMIT: limit_reg <= cfg_data[iyfq_pkg::LIMIT_W-1:0];
                default:                     delay_reg <= delay_reg;
            endcase
        end
    end

    // input register: payload unreset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_action_reg <= action;
            s1_now_reg    <= now_ms;
            s1_ok_reg     <= read_ok;
            s1_ver_reg    <= version_bytes;
            s1_bits_reg   <= yaw_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // state advances only together with the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= iyfq_pkg::READ_NONE;
            warm_reg      <= 1'b1;
            ver_flag_reg  <= 1'b0;
            ver_store_reg <= '0;
            ready_reg     <= 1'b0;
            run_reg       <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            yaw_reg       <= '0;
            ref_reg       <= '0;
        end
        else if (advance)
        begin
            kind_reg      <= kind_next;
            warm_reg      <= warm_next;
            ver_flag_reg  <= ver_flag_next;
            ver_store_reg <= ver_store_next;
            ready_reg     <= ready_next;
            run_reg       <= run_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            yaw_reg       <= yaw_next;
            ref_reg       <= ref_next;
        end
    end

    // relative yaw, wrapped into (-1800, 1800]; the difference stays within +/-7448, so one correction suffices
    assign delta = DW'(yaw_reg) - DW'(ref_reg);

    always_comb
    begin
        if (delta > ONE_HALF)
        begin
            delta_wrap = delta - TWO_TURNS;
        end
        else if (delta > HALF_TURN)
        begin
            delta_wrap = delta - FULL_TURN;
        end
        else if (delta <= -ONE_HALF)
        begin
            delta_wrap = delta + TWO_TURNS;
        end
        else if (delta <= -HALF_TURN)
        begin
            delta_wrap = delta + FULL_TURN;
        end
        else
        begin
            delta_wrap = delta;
        end
    end

    assign out_valid           = out_valid_reg;
    assign ready_res           = ready_reg;
    assign warming_up          = warm_reg;
    assign version_valid       = ver_flag_reg;
    assign read_kind           = kind_reg;
    assign yaw_tenths          = yaw_reg;
    assign relative_yaw_tenths = delta_wrap[iyfq_pkg::REL_W-1:0];
    assign good_frames         = good_reg;
    assign bad_frames          = bad_reg;
    assign version_out         = ver_store_reg;

endmodule

`default_nettype wire

// File: rtl/iyfq_checker.sv
// port-level checks for imu_yaw_frame_qualifier, attached by bind
// depends on iyfq_pkg and imu_yaw_frame_qualifier_defines.svh
`default_nettype none

`include "imu_yaw_frame_qualifier_defines.svh"

module iyfq_checker
#(
    parameter int COUNT_WIDTH = iyfq_pkg::COUNT_WIDTH_DEF
)
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic                               ready_res,
    input wire logic                               warming_up,
    input wire logic                               version_valid,
    input wire logic [1:0]                         read_kind,
    input wire logic signed [iyfq_pkg::YAW_W-1:0]  yaw_tenths,
    input wire logic signed [iyfq_pkg::REL_W-1:0]  relative_yaw_tenths,
    input wire logic [COUNT_WIDTH-1:0]             good_frames,
    input wire logic [COUNT_WIDTH-1:0]             bad_frames
);

    // stalled result holds
    `IYFQ_ASSERT_NEXT(a_result_hold, out_valid && out_stall,
        out_valid && $stable(read_kind) && $stable(yaw_tenths)
            && $stable(good_frames) && $stable(bad_frames),
        "stalled result changed")

    // no read is consumed and no version is known while warming up
    `IYFQ_ASSERT_NOW(a_warm_quiet, out_valid && warming_up,
        read_kind == iyfq_pkg::READ_NONE && !version_valid,
        "activity during warm-up")

    // an angle read needs a stored version and warm-up finished
    `IYFQ_ASSERT_NOW(a_angle_order, out_valid && read_kind == iyfq_pkg::READ_ANGLE,
        version_valid && !warming_up,
        "angle read before version")

    // ready can only be set by a good angle frame
    `IYFQ_ASSERT_NOW(a_ready_good, out_valid && ready_res,
        good_frames != '0,
        "ready without good frame")

    // wrapped relative yaw stays in (-1800, 1800]
    `IYFQ_ASSERT_NOW(a_rel_range, out_valid,
        relative_yaw_tenths >= -12'sd1799 && relative_yaw_tenths <= 12'sd1800,
        "relative yaw out of range")

endmodule

bind imu_yaw_frame_qualifier iyfq_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_iyfq_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .ready_res           (ready_res),
    .warming_up          (warming_up),
    .version_valid       (version_valid),
    .read_kind           (read_kind),
    .yaw_tenths          (yaw_tenths),
    .relative_yaw_tenths (relative_yaw_tenths),
    .good_frames         (good_frames),
    .bad_frames          (bad_frames)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for imu_yaw_frame_qualifier: directed frames, then random phases
// a shadow of the qualifier state predicts every status transaction
// depends on iyfq_pkg and the imu_yaw_frame_qualifier rtl

module tb_top;

    // frame actions
    localparam bit ACT_TICK    = 1'b0;
    localparam bit ACT_CAPTURE = 1'b1;

    // yaw scaling: 572.957795 in q10.22, and |6.5| as a single pattern
    localparam longint unsigned SCALE_Q22   = 64'd2403159171;
    localparam logic [30:0]     YAW_MAG_MAX = 31'h40D00000;
    localparam int              HALF_TURN_T = 1800;
    localparam int              FULL_TURN_T = 3600;

    // run shape
    localparam int PHASES          = 14;
    localparam int PHASE_FRAMES    = 100;
    localparam int WATCHDOG_CYCLES = 500;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        read_ok;
        logic [23:0] version_bytes;
        logic [31:0] yaw_bits;
    } frame_t;

    // one status transaction, in port order
    typedef struct packed {
        logic                       ready;
        logic                       warm;
        logic                       ver_valid;
        logic [1:0]                 kind;
        logic [iyfq_pkg::YAW_W-1:0] yaw;
        logic [iyfq_pkg::REL_W-1:0] rel;
        logic [31:0]                good;
        logic [31:0]                bad;
        logic [23:0]                version;
    } status_t;

    // shadow of the qualifier: its state, its registers and the statuses still due
    class frame_status_tracker;
        logic [iyfq_pkg::DELAY_W-1:0] delay_ms;
        logic [iyfq_pkg::LIMIT_W-1:0] fail_limit;
        bit                           warm;
        bit                           ver_ok;
        bit                           ready;
        logic [23:0]                  ver_store;
        logic [iyfq_pkg::LIMIT_W-1:0] fail_run;
        logic [31:0]                  good;
        logic [31:0]                  bad;
        int                           yaw_now;
        int                           yaw_ref;
        status_t                      status_due[$];
        int                           status_errors;
        int                           results_seen;
        int                           version_reads;
        int                           angle_reads;
        int                           captures;
        int                           ready_drops;

        function new();
            delay_ms   = iyfq_pkg::STARTUP_DELAY_RST;
            fail_limit = iyfq_pkg::FAILURE_LIMIT_RST;
            warm       = 1'b1;
            ver_ok     = 1'b0;
            ready      = 1'b0;
            ver_store  = '0;
            fail_run   = '0;
            good       = '0;
            bad        = '0;
            yaw_now    = 0;
            yaw_ref    = 0;
        endfunction

        function void set_reg(logic idx, logic [iyfq_pkg::CFG_DATA_W-1:0] val);
            if (idx == iyfq_pkg::CFG_STARTUP_DELAY)
                delay_ms = val[iyfq_pkg::DELAY_W-1:0];
            else
                fail_limit = val[iyfq_pkg::LIMIT_W-1:0];
        endfunction

        function void note_failure();
            if (bad != '1)
                bad++;
            if (fail_run < fail_limit)
                fail_run++;
            if (fail_run >= fail_limit)
                ready = 1'b0;
        endfunction

        // exact product with the scale, rounded half away from zero
        function int radians_to_tenths(logic [31:0] bits);
            int              e;
            int              sh;
            longint unsigned m;
            longint unsigned prod;
            longint unsigned mag;
            e = int'(bits[30:23]);
            m = 64'(bits[22:0]);
            if (e != 0)
            begin
                m  = m | 64'h800000;
                sh = 172 - e;
            end
            else
                sh = 171;
            if (sh > 56)
                return 0;
            prod = m * SCALE_Q22;
            mag  = (prod + (64'd1 << (sh - 1))) >> sh;
            return bits[31] ? -int'(mag) : int'(mag);
        endfunction

        function void take_frame(frame_t f);
            bit      active;
            bit      was_ready;
            logic [1:0] kind;
            int      d;
            status_t s;
            active    = 1'b1;
            was_ready = ready;
            kind      = iyfq_pkg::READ_NONE;
            if (f.action == ACT_CAPTURE)
            begin
                yaw_ref = yaw_now;
                active  = 1'b0;
                captures++;
            end
            else if (warm)
            begin
                if (f.now_ms < 32'(delay_ms))
                    active = 1'b0;
                else
                    warm = 1'b0;
            end
            if (active && !ver_ok)
            begin
                kind = iyfq_pkg::READ_VERSION;
                version_reads++;
                if (f.read_ok)
                begin
                    ver_store = f.version_bytes;
                    ver_ok    = 1'b1;
                    fail_run  = '0;
                end
                else
                    note_failure();
            end
            else if (active)
            begin
                kind = iyfq_pkg::READ_ANGLE;
                angle_reads++;
                if (!f.read_ok || f.yaw_bits[30:0] > YAW_MAG_MAX)
                    note_failure();
                else
                begin
                    yaw_now  = radians_to_tenths(f.yaw_bits);
                    fail_run = '0;
                    ready    = 1'b1;
                    if (good == 0)
                        yaw_ref = yaw_now;
                    if (good != '1)
                        good++;
                end
            end
            if (was_ready && !ready)
                ready_drops++;
            d = yaw_now - yaw_ref;
            while (d > HALF_TURN_T)
                d -= FULL_TURN_T;
            while (d <= -HALF_TURN_T)
                d += FULL_TURN_T;
            s.ready     = ready;
            s.warm      = warm;
            s.ver_valid = ver_ok;
            s.kind      = kind;
            s.yaw       = yaw_now[iyfq_pkg::YAW_W-1:0];
            s.rel       = d[iyfq_pkg::REL_W-1:0];
            s.good      = good;
            s.bad       = bad;
            s.version   = ver_store;
            status_due.push_back(s);
        endfunction

        function string show(status_t s);
            return {$sformatf("rdy %0b warm %0b ver %0b kind %0d yaw %0d ",
                              s.ready, s.warm, s.ver_valid, s.kind, $signed(s.yaw)),
                    $sformatf("rel %0d good %0d bad %0d vout %h",
                              $signed(s.rel), s.good, s.bad, s.version)};
        endfunction

        function void match_status(status_t got);
            status_t want;
            results_seen++;
            if (status_due.size() == 0)
            begin
                status_errors++;
                if (status_errors <= MAX_REPORTS)
                    $display("[%0t] status with no frame pending: %s", $realtime, show(got));
                return;
            end
            want = status_due.pop_front();
            if (got !== want)
            begin
                status_errors++;
                if (status_errors <= MAX_REPORTS)
                begin
                    $display("[%0t] status mismatch", $realtime);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    // configuration port
    logic                            cfg_write;
    logic                            cfg_index;
    logic [iyfq_pkg::CFG_DATA_W-1:0] cfg_data;

    // frame side
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] now_ms;
    logic        read_ok;
    logic [23:0] version_bytes;
    logic [31:0] yaw_bits;

    // status side
    logic                              out_valid;
    logic                              out_stall;
    logic                              ready_res;
    logic                              warming_up;
    logic                              version_valid;
    logic [1:0]                        read_kind;
    logic signed [iyfq_pkg::YAW_W-1:0] yaw_tenths;
    logic signed [iyfq_pkg::REL_W-1:0] relative_yaw_tenths;
    logic [31:0]                       good_frames;
    logic [31:0]                       bad_frames;
    logic [23:0]                       version_out;

    // idling knobs, changed per phase
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int fail_pct  = 10;
    int burst_left = 0;
    int frames_sent = 0;
    int idle_cycles = 0;

    frame_status_tracker tracker;

    imu_yaw_frame_qualifier #(
        .COUNT_WIDTH (32)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .action              (action),
        .now_ms              (now_ms),
        .read_ok             (read_ok),
        .version_bytes       (version_bytes),
        .yaw_bits            (yaw_bits),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .ready_res           (ready_res),
        .warming_up          (warming_up),
        .version_valid       (version_valid),
        .read_kind           (read_kind),
        .yaw_tenths          (yaw_tenths),
        .relative_yaw_tenths (relative_yaw_tenths),
        .good_frames         (good_frames),
        .bad_frames          (bad_frames),
        .version_out         (version_out)
    );

    always #4 clk = ~clk;

    // monitor: values seen here are the ones the block saw at this edge,
    // since every driver updates through nonblocking assignments
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // note the frame first so a same-edge status never finds the queue short
            if (in_valid && !in_stall)
                tracker.take_frame(frame_t'({action, now_ms, read_ok, version_bytes, yaw_bits}));
            if (out_valid && !out_stall)
                tracker.match_status(status_t'({ready_res, warming_up, version_valid, read_kind,
                                                yaw_tenths, relative_yaw_tenths, good_frames,
                                                bad_frames, version_out}));
            // watchdog on cycles without any transaction
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, tracker.status_due.size());
                $display("imu_yaw_frame_qualifier regression: fail");
                $finish;
            end
        end
    end

    // status side back-pressure in random bursts
    initial
    begin
        int span;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                span = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // present one frame, holding it until the block takes it
    task automatic drive_frame(frame_t f);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        {action, now_ms, read_ok, version_bytes, yaw_bits} <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frames_sent++;
    endtask

    // drain: every status back, then a few quiet cycles for the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.results_seen < frames_sent)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // register write, only called once settled
    task automatic write_reg(logic idx, logic [iyfq_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic frame_t mk(bit act, logic [31:0] now, bit ok, logic [23:0] ver,
                                  logic [31:0] bits);
        return {act, now, ok, ver, bits};
    endfunction

    // random frame: mostly in-range yaw, with rejects, specials and raw noise
    function automatic frame_t random_frame();
        frame_t      f;
        logic [31:0] r;
        logic [7:0]  expo;
        logic [22:0] mant;
        bit          sgn;
        int          pick;
        f.action = ($urandom_range(0, 11) == 0) ? ACT_CAPTURE : ACT_TICK;
        f.now_ms = $urandom();
        r = $urandom();
        f.version_bytes = r[23:0];
        f.read_ok = ($urandom_range(0, 99) >= fail_pct);
        if (burst_left > 0)
        begin
            f.read_ok = 1'b0;
            burst_left--;
        end
        r    = $urandom();
        mant = r[22:0];
        sgn  = r[31];
        pick = $urandom_range(0, 19);
        if (pick < 13)
        begin
            // normal magnitude up to 6.5
            expo = 8'($urandom_range(112, 129));
            if (expo == 8'd129)
                mant = mant & 23'h4FFFFF;
            f.yaw_bits = {sgn, expo, mant};
        end
        else if (pick < 15)
            // around the range limit
            f.yaw_bits = {sgn, YAW_MAG_MAX - 31'd1 + 31'(r[1:0])};
        else if (pick == 15)
            // zero and subnormals
            f.yaw_bits = {sgn, 8'd0, r[24] ? mant : 23'd0};
        else if (pick == 16)
            // infinities and nans
            f.yaw_bits = {sgn, 8'hFF, r[24] ? mant : 23'd0};
        else if (pick == 17)
            // finite but far beyond the limit
            f.yaw_bits = {sgn, 8'($urandom_range(130, 254)), mant};
        else
            f.yaw_bits = $urandom();
        return f;
    endfunction

    initial
    begin
        int p;
        int n;
        logic [iyfq_pkg::CFG_DATA_W-1:0] dly;
        logic [iyfq_pkg::CFG_DATA_W-1:0] lim;
        tracker       = new();
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = iyfq_pkg::CFG_STARTUP_DELAY;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = ACT_TICK;
        now_ms        = '0;
        read_ok       = 1'b0;
        version_bytes = '0;
        yaw_bits      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up under the reset settings, capture while warming
        drive_frame(mk(ACT_TICK, 32'd0, 1'b1, 24'h000000, 32'h00000000));
        drive_frame(mk(ACT_TICK, 32'd4999, 1'b1, 24'hFFFFFF, 32'h40D00000));
        drive_frame(mk(ACT_CAPTURE, 32'hFFFFFFFF, 1'b1, 24'h000000, 32'h00000000));
        settle();
        write_reg(iyfq_pkg::CFG_STARTUP_DELAY, 16'hFFFF);

        // leave warm-up exactly at the delay, first version read fails
        drive_frame(mk(ACT_TICK, 32'd65534, 1'b1, 24'h123456, 32'h00000000));
        drive_frame(mk(ACT_TICK, 32'd65535, 1'b0, 24'h000000, 32'h00000000));
        drive_frame(mk(ACT_TICK, 32'd70000, 1'b1, 24'hA5C3FF, 32'h00000000));

        // angle reads: range edges, rejects, failure run past the limit
        drive_frame(mk(ACT_TICK, 32'd70010, 1'b1, 24'h000000, 32'h40D00000));
        drive_frame(mk(ACT_TICK, 32'd70020, 1'b1, 24'h000000, 32'hC0D00000));
        drive_frame(mk(ACT_TICK, 32'd70030, 1'b1, 24'h000000, 32'h40D00001));
        drive_frame(mk(ACT_TICK, 32'd70040, 1'b1, 24'h000000, 32'h7FC00000));
        drive_frame(mk(ACT_TICK, 32'd70050, 1'b1, 24'h000000, 32'h7F800000));
        drive_frame(mk(ACT_TICK, 32'd70060, 1'b1, 24'h000000, 32'hFF800000));
        drive_frame(mk(ACT_TICK, 32'd70070, 1'b0, 24'h000000, 32'h3F800000));

        // negative zero and subnormals convert to zero
        drive_frame(mk(ACT_TICK, 32'd70080, 1'b1, 24'h000000, 32'h80000000));
        drive_frame(mk(ACT_TICK, 32'd70090, 1'b1, 24'h000000, 32'h00000001));
        drive_frame(mk(ACT_TICK, 32'd70100, 1'b1, 24'h000000, 32'h807FFFFF));

        // reference capture, then about half a turn either way
        drive_frame(mk(ACT_CAPTURE, 32'd70110, 1'b1, 24'h000000, 32'h00000000));
        drive_frame(mk(ACT_TICK, 32'd70120, 1'b1, 24'h000000, 32'h3F800000));
        drive_frame(mk(ACT_TICK, 32'd70130, 1'b1, 24'h000000, 32'hC0490FDB));
        drive_frame(mk(ACT_TICK, 32'd70140, 1'b1, 24'h000000, 32'h40490FDB));
        drive_frame(mk(ACT_CAPTURE, 32'hFFFFFFFF, 1'b0, 24'hFFFFFF, 32'hFFFFFFFF));
        drive_frame(mk(ACT_TICK, 32'hFFFFFFFF, 1'b1, 24'h000000, 32'h33800000));
        settle();

        // zero failure limit: any failure drops ready at once
        write_reg(iyfq_pkg::CFG_FAILURE_LIMIT, 16'd0);
        drive_frame(mk(ACT_TICK, 32'd80000, 1'b0, 24'h000000, 32'h3F800000));
        drive_frame(mk(ACT_TICK, 32'd80010, 1'b1, 24'h000000, 32'hBF000000));
        drive_frame(mk(ACT_TICK, 32'd80020, 1'b1, 24'h000000, 32'h7F800001));

        // random phases, each under its own register settings and idling mix
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    lim = 16'd0;
                    dly = 16'd0;
                end
                1:
                begin
                    lim = 16'd15;
                    dly = 16'hFFFF;
                end
                2:
                begin
                    lim = 16'd1;
                    dly = 16'd5000;
                end
                default:
                begin
                    lim = 16'($urandom_range(0, 15));
                    dly = 16'($urandom());
                end
            endcase
            write_reg(iyfq_pkg::CFG_FAILURE_LIMIT, lim);
            write_reg(iyfq_pkg::CFG_STARTUP_DELAY, dly);
            case ($urandom_range(0, 2))
                0:       fail_pct = 3;
                1:       fail_pct = 15;
                default: fail_pct = 45;
            endcase
            // the last phases run with no idling at all
            gaps_on   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            stalls_on = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                // occasional long failure run so high limits are reached too
                if (burst_left == 0 && $urandom_range(0, 39) == 0)
                    burst_left = $urandom_range(1, 17);
                drive_frame(random_frame());
            end
        end
        settle();
        repeat (6) @(posedge clk);

        $display("run covered %0d frames: %0d version reads, %0d angle reads, %0d captures",
                 frames_sent, tracker.version_reads, tracker.angle_reads, tracker.captures);
        $display("ready dropped %0d times, %0d statuses checked, %0d errors, %0d left pending",
                 tracker.ready_drops, tracker.results_seen, tracker.status_errors,
                 tracker.status_due.size());
        if (tracker.status_errors == 0 && tracker.status_due.size() == 0)
            $display("imu_yaw_frame_qualifier regression: pass");
        else
            $display("imu_yaw_frame_qualifier regression: fail");
        $finish;
    end

endmodule
